// ===== design/rcfft_pkg.sv =====
// shared constants, command struct and twiddle table builder for the radix-2 fft core
// no dependencies
`default_nettype none

package rcfft_pkg;

  localparam int unsigned MaxLog2PointsDef = 10;
  localparam int unsigned SampleWidthDef   = 16;
  localparam int unsigned TwiddleWidthDef  = 16;
  localparam int unsigned CfgWidth         = 4;
  localparam int unsigned Log2PointsRst    = 10;
  localparam int unsigned TwPack           = 24;
  localparam longint unsigned PiQ30        = 64'd3373259426;

  // commands from the sequencer to the datapath
  typedef struct packed {
    logic load_wr;
    logic cap_a;
    logic mul_en;
    logic sum_en;
    logic wr_a;
    logic wr_b;
    logic out_ld;
    logic out_zero;
  } dp_cmd_t;

  // shift-subtract quotient, elaboration only
  function automatic longint unsigned udiv(longint unsigned num, longint unsigned den);
    longint unsigned rem;
    longint unsigned q;
    rem = 0;
    q   = 0;
    for (int i = 63; i >= 0; i--) begin
      rem = (rem << 1) | ((num >> i) & 64'd1);
      if (rem >= den) begin
        rem = rem - den;
        q   = q | (64'd1 << i);
      end
    end
    return q;
  endfunction

  // q2.30 to twiddle format, negatives to zero, round half up, clamp to full scale
  function automatic longint to_twiddle(longint v, int unsigned tw);
    longint r;
    longint maxv;
    maxv = (64'sd1 <<< (tw - 1)) - 1;
    if (v < 0) v = 0;
    r = (v + (64'sd1 <<< (30 - tw))) >>> (31 - tw);
    return (r > maxv) ? maxv : r;
  endfunction

  // {sin, cos} for table entry k, taylor series in q2.30
  function automatic logic [2*TwPack-1:0] tw_entry(int unsigned k, int unsigned ml,
                                                   int unsigned tw);
    longint unsigned nmax;
    longint unsigned kk;
    longint unsigned x;
    longint unsigned t;
    longint c;
    longint s;
    longint cq;
    longint sq;
    logic neg;
    logic [2*TwPack-1:0] res;
    nmax = 64'd1 << ml;
    kk   = k;
    neg  = 1'b0;
    if (4 * longint'(k) > nmax) begin
      kk  = (nmax >> 1) - k;
      neg = 1'b1;
    end
    x = (PiQ30 * 2 * kk + (64'd1 << (ml - 1))) >> ml;
    t = 64'd1 << 30;
    c = 64'sd1 <<< 30;
    s = 0;
    for (int n = 1; n < 28; n++) begin
      t = udiv((t * x) >> 30, longint'(n));
      case (n % 4)
        0:       c = c + longint'(t);
        1:       s = s + longint'(t);
        2:       c = c - longint'(t);
        default: s = s - longint'(t);
      endcase
    end
    cq = to_twiddle(c, tw);
    sq = to_twiddle(s, tw);
    if (neg) cq = -cq;
    res[TwPack-1:0]        = cq[TwPack-1:0];
    res[2*TwPack-1:TwPack] = sq[TwPack-1:0];
    return res;
  endfunction

endpackage

`default_nettype wire

// ===== design/rcfft_dpath.sv =====
// datapath: working store, twiddle rom, butterfly unit and bin output registers
// depends on rcfft_pkg
`default_nettype none

module rcfft_dpath #(
  parameter int unsigned MAX_LOG2_POINTS = rcfft_pkg::MaxLog2PointsDef,
  parameter int unsigned SAMPLE_WIDTH    = rcfft_pkg::SampleWidthDef,
  parameter int unsigned TWIDDLE_WIDTH   = rcfft_pkg::TwiddleWidthDef,
  localparam int unsigned TwAw = (MAX_LOG2_POINTS > 1) ? MAX_LOG2_POINTS - 1 : 1,
  localparam int unsigned OutW = SAMPLE_WIDTH + MAX_LOG2_POINTS
) (
  input  wire                                 clk_i,
  input  rcfft_pkg::dp_cmd_t                  cmd_i,
  input  wire                                 rd_en_i,
  input  wire  [MAX_LOG2_POINTS-1:0]          rd_addr_i,
  input  wire  [MAX_LOG2_POINTS-1:0]          wr_addr_i,
  input  wire  [TwAw-1:0]                     tw_idx_i,
  input  wire  signed [SAMPLE_WIDTH-1:0]      sample_re_i,
  input  wire  signed [SAMPLE_WIDTH-1:0]      sample_im_i,
  output logic signed [OutW-1:0]              bin_re_o,
  output logic signed [OutW-1:0]              bin_im_o
);
  import rcfft_pkg::*;

  localparam int unsigned Ww   = SAMPLE_WIDTH + MAX_LOG2_POINTS + 1;
  localparam int unsigned Tw   = TWIDDLE_WIDTH;
  localparam int unsigned Pw   = Ww + Tw;
  localparam int unsigned TwN  = 2 ** TwAw;
  localparam int unsigned Dep  = 2 ** MAX_LOG2_POINTS;

  logic [Tw-1:0] cos_rom [TwN];
  logic [Tw-1:0] sin_rom [TwN];

  for (genvar k = 0; k < TwN; k++) begin : g_tw
    localparam logic [2*TwPack-1:0] Ent = tw_entry(k, MAX_LOG2_POINTS, TWIDDLE_WIDTH);
    assign cos_rom[k] = Ent[Tw-1:0];
    assign sin_rom[k] = Ent[TwPack+Tw-1:TwPack];
  end

  logic signed [Tw-1:0] wr_q, wi_q;

  always_ff @(posedge clk_i) begin
    wr_q <= cos_rom[tw_idx_i];
    wi_q <= Tw'(0) - sin_rom[tw_idx_i];
  end

  // working store, one word holds {im, re}
  logic [2*Ww-1:0] mem [Dep];
  logic [2*Ww-1:0] rd_q;
  logic [2*Ww-1:0] wdata;
  logic            wr_en;

  logic signed [Ww-1:0] xa_re_q, xa_im_q, xb_re, xb_im;
  logic signed [Pw-1:0] p_rr_q, p_ii_q, p_ri_q, p_ir_q;
  logic signed [Pw-1:0] sh_rr, sh_ii, sh_ri, sh_ir;
  logic signed [Ww-1:0] tr_q, ti_q;

  assign xb_re = rd_q[Ww-1:0];
  assign xb_im = rd_q[2*Ww-1:Ww];
  assign wr_en = cmd_i.load_wr | cmd_i.wr_a | cmd_i.wr_b;

  always_comb begin
    if (cmd_i.load_wr) begin
      wdata = {{(Ww-SAMPLE_WIDTH){sample_im_i[SAMPLE_WIDTH-1]}}, sample_im_i,
               {(Ww-SAMPLE_WIDTH){sample_re_i[SAMPLE_WIDTH-1]}}, sample_re_i};
    end else if (cmd_i.wr_a) begin
      wdata = {xa_im_q + ti_q, xa_re_q + tr_q};
    end else begin
      wdata = {xa_im_q - ti_q, xa_re_q - tr_q};
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      mem[wr_addr_i] <= wdata;
    end
    if (rd_en_i) begin
      rd_q <= mem[rd_addr_i];
    end
  end

  // each product floors separately before the sum
  assign sh_rr = p_rr_q >>> (Tw - 1);
  assign sh_ii = p_ii_q >>> (Tw - 1);
  assign sh_ri = p_ri_q >>> (Tw - 1);
  assign sh_ir = p_ir_q >>> (Tw - 1);

  always_ff @(posedge clk_i) begin
    if (cmd_i.cap_a) begin
      xa_re_q <= xb_re;
      xa_im_q <= xb_im;
    end
    if (cmd_i.mul_en) begin
      p_rr_q <= Pw'(wr_q * xb_re);
      p_ii_q <= Pw'(wi_q * xb_im);
      p_ri_q <= Pw'(wr_q * xb_im);
      p_ir_q <= Pw'(wi_q * xb_re);
    end
    if (cmd_i.sum_en) begin
      tr_q <= sh_rr[Ww-1:0] - sh_ii[Ww-1:0];
      ti_q <= sh_ri[Ww-1:0] + sh_ir[Ww-1:0];
    end
  end

  // saturate working words into the bin width
  logic signed [OutW-1:0] sat_re, sat_im;
  localparam logic signed [OutW-1:0] SatHi = {1'b0, {(OutW-1){1'b1}}};
  localparam logic signed [OutW-1:0] SatLo = {1'b1, {(OutW-1){1'b0}}};

  always_comb begin
    if (xb_re[Ww-1] == xb_re[Ww-2]) sat_re = xb_re[OutW-1:0];
    else                            sat_re = xb_re[Ww-1] ? SatLo : SatHi;
    if (xb_im[Ww-1] == xb_im[Ww-2]) sat_im = xb_im[OutW-1:0];
    else                            sat_im = xb_im[Ww-1] ? SatLo : SatHi;
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.out_ld) begin
      bin_re_o <= sat_re;
      bin_im_o <= sat_im;
    end else if (cmd_i.out_zero) begin
      bin_re_o <= '0;
      bin_im_o <= '0;
    end
  end

endmodule

`default_nettype wire

// ===== design/rcfft_ctrl.sv =====
// sequencer: frame counters, butterfly address generation and output handshake
// depends on rcfft_pkg
`default_nettype none

module rcfft_ctrl #(
  parameter int unsigned MAX_LOG2_POINTS = rcfft_pkg::MaxLog2PointsDef,
  localparam int unsigned TwAw = (MAX_LOG2_POINTS > 1) ? MAX_LOG2_POINTS - 1 : 1
) (
  input  wire                             clk_i,
  input  wire                             rst_ni,
  input  wire                             cfg_valid_i,
  output logic                            cfg_ready_o,
  input  wire  [rcfft_pkg::CfgWidth-1:0]  cfg_data_i,
  input  wire                             in_valid_i,
  output logic                            in_ready_o,
  input  wire                             func_i,
  output logic                            out_valid_o,
  input  wire                             out_ready_i,
  output logic [MAX_LOG2_POINTS-1:0]      bin_index_o,
  output logic                            bin_last_o,
  output logic                            ready_res_o,
  output rcfft_pkg::dp_cmd_t              cmd_o,
  output logic                            rd_en_o,
  output logic [MAX_LOG2_POINTS-1:0]      rd_addr_o,
  output logic [MAX_LOG2_POINTS-1:0]      wr_addr_o,
  output logic [TwAw-1:0]                 tw_idx_o
);
  import rcfft_pkg::*;

  localparam int unsigned Aw = MAX_LOG2_POINTS;
  localparam int unsigned Nw = MAX_LOG2_POINTS + 1;
  localparam int unsigned Lw = $clog2(MAX_LOG2_POINTS + 1);

  typedef enum logic [2:0] {
    ST_IDLE, ST_RDOUT, ST_BF_RA, ST_BF_RB, ST_BF_MUL, ST_BF_SUM, ST_BF_WA, ST_BF_WB
  } state_e;

  state_e               state_q;
  logic [CfgWidth-1:0]  cfg_q;
  logic [Nw-1:0]        lcnt_q;
  logic [Aw-1:0]        rptr_q;
  logic                 done_q;
  logic [Lw-1:0]        stage_q;
  logic [Aw-1:0]        j_q;

  logic [CfgWidth-1:0]  leff;
  logic [Nw-1:0]        npts, eff_cnt, cnt_inc, rptr_inc;
  logic [Aw-1:0]        half, rev, load_addr, mask, mval, a_addr, b_addr, tw_full;
  logic                 acc, last_j, last_stage;

  always_comb begin
    if (cfg_q == '0)                                leff = CfgWidth'(1);
    else if (cfg_q > CfgWidth'(MAX_LOG2_POINTS))    leff = CfgWidth'(MAX_LOG2_POINTS);
    else                                            leff = cfg_q;
  end

  assign npts     = Nw'(1) << leff;
  assign half     = Aw'(npts >> 1);
  assign acc      = in_valid_i & in_ready_o;
  assign eff_cnt  = done_q ? '0 : lcnt_q;
  assign cnt_inc  = eff_cnt + Nw'(1);
  assign rptr_inc = Nw'(rptr_q) + Nw'(1);

  // samples land at bit-reversed addresses, so no reorder pass is needed
  always_comb begin
    for (int b = 0; b < Aw; b++) begin
      rev[Aw-1-b] = eff_cnt[b];
    end
  end
  assign load_addr = rev >> (CfgWidth'(MAX_LOG2_POINTS) - leff);

  assign mask       = (Aw'(1) << stage_q) - Aw'(1);
  assign mval       = j_q & mask;
  assign a_addr     = ((j_q >> stage_q) << (stage_q + Lw'(1))) | mval;
  assign b_addr     = a_addr | (Aw'(1) << stage_q);
  assign tw_full    = mval << (Lw'(MAX_LOG2_POINTS - 1) - stage_q);
  assign tw_idx_o   = tw_full[TwAw-1:0];
  assign last_j     = (j_q + Aw'(1)) == half;
  assign last_stage = CfgWidth'(stage_q) == (leff - CfgWidth'(1));

  assign in_ready_o  = (state_q == ST_IDLE) && !out_valid_o;
  assign cfg_ready_o = (state_q == ST_IDLE);

  always_comb begin
    cmd_o     = '0;
    rd_en_o   = 1'b0;
    rd_addr_o = a_addr;
    wr_addr_o = a_addr;
    unique case (state_q)
      ST_IDLE: begin
        if (acc) begin
          if (!func_i) begin
            cmd_o.load_wr = 1'b1;
            wr_addr_o     = load_addr;
          end else if (done_q) begin
            rd_en_o   = 1'b1;
            rd_addr_o = rptr_q;
          end else begin
            cmd_o.out_zero = 1'b1;
          end
        end
      end
      ST_RDOUT:  cmd_o.out_ld = 1'b1;
      ST_BF_RA:  rd_en_o = 1'b1;
      ST_BF_RB: begin
        rd_en_o     = 1'b1;
        rd_addr_o   = b_addr;
        cmd_o.cap_a = 1'b1;
      end
      ST_BF_MUL: cmd_o.mul_en = 1'b1;
      ST_BF_SUM: cmd_o.sum_en = 1'b1;
      ST_BF_WA:  cmd_o.wr_a = 1'b1;
      ST_BF_WB: begin
        cmd_o.wr_b = 1'b1;
        wr_addr_o  = b_addr;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      cfg_q       <= CfgWidth'(Log2PointsRst);
      lcnt_q      <= '0;
      rptr_q      <= '0;
      done_q      <= 1'b0;
      stage_q     <= '0;
      j_q         <= '0;
      out_valid_o <= 1'b0;
      bin_index_o <= '0;
      bin_last_o  <= 1'b0;
      ready_res_o <= 1'b0;
    end else begin
      if (out_valid_o && out_ready_i) out_valid_o <= 1'b0;
      if (cfg_valid_i && cfg_ready_o) begin
        cfg_q  <= cfg_data_i;
        lcnt_q <= '0;
        rptr_q <= '0;
        done_q <= 1'b0;
      end
      unique case (state_q)
        ST_IDLE: begin
          if (acc) begin
            if (!func_i) begin
              done_q <= 1'b0;
              rptr_q <= '0;
              lcnt_q <= cnt_inc;
              if (cnt_inc >= npts) begin
                state_q <= ST_BF_RA;
                stage_q <= '0;
                j_q     <= '0;
              end
            end else if (done_q) begin
              state_q     <= ST_RDOUT;
              bin_index_o <= rptr_q;
              bin_last_o  <= (rptr_inc == npts);
              ready_res_o <= 1'b1;
              rptr_q      <= (rptr_inc >= npts) ? '0 : Aw'(rptr_inc);
            end else begin
              out_valid_o <= 1'b1;
              bin_index_o <= '0;
              bin_last_o  <= 1'b0;
              ready_res_o <= 1'b0;
            end
          end
        end
        ST_RDOUT: begin
          out_valid_o <= 1'b1;
          state_q     <= ST_IDLE;
        end
        ST_BF_RA:  state_q <= ST_BF_RB;
        ST_BF_RB:  state_q <= ST_BF_MUL;
        ST_BF_MUL: state_q <= ST_BF_SUM;
        ST_BF_SUM: state_q <= ST_BF_WA;
        ST_BF_WA:  state_q <= ST_BF_WB;
        ST_BF_WB: begin
          if (last_j) begin
            j_q <= '0;
            if (last_stage) begin
              done_q  <= 1'b1;
              state_q <= ST_IDLE;
            end else begin
              stage_q <= stage_q + Lw'(1);
              state_q <= ST_BF_RA;
            end
          end else begin
            j_q     <= j_q + Aw'(1);
            state_q <= ST_BF_RA;
          end
        end
        default: state_q <= ST_IDLE;
      endcase
    end
  end

endmodule

`default_nettype wire

// ===== design/radix2_complex_fft_core.sv =====
// load: a beat is stored as it is taken. read: a bin passes the store read register, then
// the output registers; a zero bin skips the store. the last load of a frame starts the
// transform, no input taken meanwhile: each butterfly reads a and b, multiplies, sums and
// writes a and b on the single store port pair. one beat in flight at a time; a held bin
// blocks input until taken. reset (async, active low) gives log2 length 10, empty frame;
// store contents undefined. depends on rcfft_pkg, rcfft_ctrl, rcfft_dpath
`default_nettype none

module radix2_complex_fft_core #(
  parameter int unsigned MAX_LOG2_POINTS = rcfft_pkg::MaxLog2PointsDef,
  parameter int unsigned SAMPLE_WIDTH    = rcfft_pkg::SampleWidthDef,
  parameter int unsigned TWIDDLE_WIDTH   = rcfft_pkg::TwiddleWidthDef,
  localparam int unsigned OutW   = SAMPLE_WIDTH + MAX_LOG2_POINTS,
  localparam int unsigned InTdw  = ((2 * SAMPLE_WIDTH + 7) / 8) * 8,
  localparam int unsigned OutTdw = ((2 * OutW + MAX_LOG2_POINTS + 7) / 8) * 8
) (
  input  wire                             clk_i,
  input  wire                             rst_ni,
  // log2 length register
  input  wire                             cfg_valid_i,
  output logic                            cfg_ready_o,
  input  wire  [rcfft_pkg::CfgWidth-1:0]  cfg_data_i,
  // input stream
  input  wire                             s_axis_tvalid_i,
  output logic                            s_axis_tready_o,
  input  wire  [InTdw-1:0]                s_axis_tdata_i,   // sample_re, sample_im
  input  wire                             s_axis_tuser_i,   // func: 0 load, 1 read bin
  // output stream
  output logic                            m_axis_tvalid_o,
  input  wire                             m_axis_tready_i,
  output logic [OutTdw-1:0]               m_axis_tdata_o,   // bin_re, bin_im, bin_index
  output logic                            m_axis_tlast_o,   // bin_last
  output logic                            m_axis_tuser_o    // ready_res
);
  import rcfft_pkg::*;

  localparam int unsigned TwAw = (MAX_LOG2_POINTS > 1) ? MAX_LOG2_POINTS - 1 : 1;

  dp_cmd_t                      cmd;
  logic                         rd_en;
  logic [MAX_LOG2_POINTS-1:0]   rd_addr, wr_addr, bin_index;
  logic [TwAw-1:0]              tw_idx;
  logic signed [OutW-1:0]       bin_re, bin_im;

  // sequencer owns every counter and the beat handshakes
  rcfft_ctrl #(
    .MAX_LOG2_POINTS (MAX_LOG2_POINTS)
  ) u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_data_i  (cfg_data_i),
    .in_valid_i  (s_axis_tvalid_i),
    .in_ready_o  (s_axis_tready_o),
    .func_i      (s_axis_tuser_i),
    .out_valid_o (m_axis_tvalid_o),
    .out_ready_i (m_axis_tready_i),
    .bin_index_o (bin_index),
    .bin_last_o  (m_axis_tlast_o),
    .ready_res_o (m_axis_tuser_o),
    .cmd_o       (cmd),
    .rd_en_o     (rd_en),
    .rd_addr_o   (rd_addr),
    .wr_addr_o   (wr_addr),
    .tw_idx_o    (tw_idx)
  );

  // store, twiddle rom and butterfly arithmetic
  rcfft_dpath #(
    .MAX_LOG2_POINTS (MAX_LOG2_POINTS),
    .SAMPLE_WIDTH    (SAMPLE_WIDTH),
    .TWIDDLE_WIDTH   (TWIDDLE_WIDTH)
  ) u_dpath (
    .clk_i       (clk_i),
    .cmd_i       (cmd),
    .rd_en_i     (rd_en),
    .rd_addr_i   (rd_addr),
    .wr_addr_i   (wr_addr),
    .tw_idx_i    (tw_idx),
    .sample_re_i (s_axis_tdata_i[SAMPLE_WIDTH-1:0]),
    .sample_im_i (s_axis_tdata_i[2*SAMPLE_WIDTH-1:SAMPLE_WIDTH]),
    .bin_re_o    (bin_re),
    .bin_im_o    (bin_im)
  );

  // pack the bin beat, zero fill to whole bytes
  assign m_axis_tdata_o = OutTdw'({bin_index, bin_im, bin_re});

  // input is never taken while a bin beat is held
  a_ready_excl: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tready_o |-> !m_axis_tvalid_o)
    else $error("input ready while bin pending");

  // a bin from no finished frame carries all zeros
  a_zero_bin: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid_o && !m_axis_tuser_o) |-> (m_axis_tdata_o == '0) && !m_axis_tlast_o)
    else $error("nonzero bin without finished frame");

  // the log2 length register is never written while a butterfly multiplies or writes back
  a_cfg_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cfg_valid_i && cfg_ready_o) |-> !cmd.mul_en && !cmd.wr_a && !cmd.wr_b)
    else $error("register write during transform");

endmodule

`default_nettype wire
